### sv/physical_page_allocator_assert.svh
// Assertion macros shared by the page allocator RTL.
// Expects signals named clk and rst in the including module.
`ifndef PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppa_pkg.sv
// Shared types and constants of the physical page allocator.
// No dependencies; used by ppa_find and physical_page_allocator.
package ppa_pkg;

  localparam int ADDR_W         = 32;
  localparam int CFG_W          = 14;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_DATA_W     = 48;
  localparam int STATUS_W       = 2;
  localparam int WORD_BITS      = 64;
  localparam int WORD_IDX_W     = 6;
  localparam int DEF_MAX_PAGES  = 8192;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 14'd257;
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 14'd8192;
  localparam logic [CFG_W-1:0] FREE_MAX       = 14'h3FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_DONE
  } fsm_t;

  // Lowest free page within one bitmap word.
  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] bit_idx;
    logic [WORD_BITS-1:0]  onehot;
  } find_t;

endpackage

### sv/ppa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ppa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ppa_find.sv
// Masked first-free search over one occupancy word of the page bitmap.
// Depends on ppa_pkg.
module ppa_find (
  input  logic [ppa_pkg::WORD_BITS-1:0]  word,
  input  logic                           at_first,
  input  logic                           at_last,
  input  logic [ppa_pkg::WORD_IDX_W-1:0] lo_bit,
  input  logic [ppa_pkg::WORD_IDX_W-1:0] hi_bit,
  output ppa_pkg::find_t                 res
);
  import ppa_pkg::*;

  localparam logic [WORD_BITS-1:0] WORD_ONE  = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] WORD_ALL  = {WORD_BITS{1'b1}};
  localparam logic [WORD_IDX_W-1:0] TOP_BIT  = WORD_IDX_W'(WORD_BITS - 1);

  logic [WORD_BITS-1:0]  lo_mask;
  logic [WORD_BITS-1:0]  hi_mask;
  logic [WORD_BITS-1:0]  cand;
  logic [WORD_BITS-1:0]  onehot;
  logic [WORD_IDX_W-1:0] idx;

  always_comb begin
    // Keep pages below first_page and at or above the bound out of the search.
    lo_mask = at_first ? ~((WORD_ONE << lo_bit) - WORD_ONE) : WORD_ALL;
    hi_mask = at_last ? (WORD_ALL >> (TOP_BIT - hi_bit)) : WORD_ALL;
    cand    = ~word & lo_mask & hi_mask;
    onehot  = cand & (~cand + WORD_ONE);
    idx     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | WORD_IDX_W'(i);
      end
    end
    res.found   = |cand;
    res.bit_idx = idx;
    res.onehot  = onehot;
  end

endmodule

### sv/physical_page_allocator.sv
// Physical page allocator: first-fit page frames over an occupancy bitmap.
// Depends on ppa_pkg, ppa_ram, ppa_find and physical_page_allocator_assert.svh.
//
// One request word at a time. An allocate walks the bitmap RAM one 64-page
// word per cycle, starting at the word that holds first_page, and claims the
// lowest free page below min(page_count, MAX_PAGES); it reads at most
// MAX_PAGES/64 words up to the hit (128 at the default size). A release
// reads the word of its page, checks it and writes it back; a malformed
// address goes straight to the result. A page's reference count only ever
// moves between zero and one (allocation claims free pages only), so one
// bit per page holds the whole count. After reset a clearing pass zeroes
// the bitmap, one word per cycle over all MAX_PAGES/64 words (128 at the
// default), while no request is taken; configuration writes are taken at
// any time and reload the free count, but belong to idle periods. The
// result register parts the two sides: a new request is taken while the
// previous result still waits for m_tready.
`include "physical_page_allocator_assert.svh"

module physical_page_allocator #(
  parameter int MAX_PAGES  = ppa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = ppa_pkg::DEF_PAGE_SHIFT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ppa_pkg::ADDR_W-1:0]        s_tdata,    // [31:0] page_address
  input  logic                              s_tuser,    // [0] command
  // Result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ppa_pkg::OUT_DATA_W-1:0]    m_tdata,    // [31:0] result_address,
                                                        // [45:32] free_count, rest 0
  output logic [ppa_pkg::STATUS_W-1:0]      m_tuser,    // [1:0] status
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppa_pkg::CFG_W-1:0]         cfg_data
);
  import ppa_pkg::*;

  localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [WAW-1:0]    LAST_WORD   = WAW'(WORDS - 1);
  localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

  // Effective bound of the managed range.
  function automatic logic [ADDR_W-1:0] bound_of(input logic [CFG_W-1:0] pc);
    return (ADDR_W'(pc) > ADDR_W'(MAX_PAGES)) ? ADDR_W'(MAX_PAGES) : ADDR_W'(pc);
  endfunction

  function automatic logic [CFG_W-1:0] free_base(input logic [CFG_W-1:0] fp,
                                                 input logic [CFG_W-1:0] pc);
    logic [ADDR_W-1:0] t;
    t = bound_of(pc);
    return (t > ADDR_W'(fp)) ? CFG_W'(t - ADDR_W'(fp)) : '0;
  endfunction

  // Control state
  fsm_t             state, state_next;
  logic [WAW-1:0]   clr_w;
  logic             more;      // scan reads still to issue
  logic             dvalid;    // RAM read data belongs to the scan
  logic [CFG_W-1:0] first_page;
  logic [CFG_W-1:0] page_count;
  logic [CFG_W-1:0] free_left;

  // Request payload held across the operation
  logic [WAW-1:0]        issue_w;
  logic [WAW-1:0]        data_w;
  logic [WAW-1:0]        start_w;
  logic [WAW-1:0]        last_w;
  logic [WORD_IDX_W-1:0] lo_bit;
  logic [WORD_IDX_W-1:0] hi_bit;
  logic [WAW-1:0]        rel_w;
  logic [WORD_IDX_W-1:0] rel_bit;
  logic [ADDR_W-1:0]     res_addr;
  status_t               res_status;

  // RAM port
  logic                 ram_we;
  logic [WAW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WAW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] rd_data;

  find_t fnd;

  // Request decode
  logic              in_acc;
  logic              out_free;
  logic              cfg_acc;
  cmd_t              cmd;
  logic [ADDR_W-1:0] total;
  logic [ADDR_W-1:0] total_m1;
  logic              scan_ok;
  logic [ADDR_W-1:0] rel_idx;
  logic              rel_bad;
  logic              scan_done;
  logic              rel_hit;
  logic [CFG_W-1:0]  new_first;
  logic [CFG_W-1:0]  new_count;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign cmd      = cmd_t'(s_tuser);
  assign total    = bound_of(page_count);
  assign total_m1 = total - ADDR_W'(1);
  assign scan_ok  = total > ADDR_W'(first_page);
  assign rel_idx  = s_tdata >> PAGE_SHIFT;
  assign rel_bad  = ((s_tdata & OFFSET_MASK) != '0) || (rel_idx < ADDR_W'(first_page)) ||
                    (rel_idx >= total);
  assign scan_done = dvalid && (fnd.found || (data_w == last_w));
  assign rel_hit   = rd_data[rel_bit];

  assign new_first = (cfg_index == CFG_FIRST_PAGE) ? cfg_data : first_page;
  assign new_count = (cfg_index == CFG_PAGE_COUNT) ? cfg_data : page_count;

  ppa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  ppa_find u_find (
    .word     (rd_data),
    .at_first (data_w == start_w),
    .at_last  (data_w == last_w),
    .lo_bit   (lo_bit),
    .hi_bit   (hi_bit),
    .res      (fnd)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_w == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_ALLOC) begin
            state_next = scan_ok ? S_SCAN : S_DONE;
          end else begin
            state_next = rel_bad ? S_DONE : S_REL;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DONE;
        end
      end
      S_REL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs: request ready, the clearing writes and the bitmap read-modify-write
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = data_w;
    ram_wdata = rd_data;
    ram_raddr = issue_w;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_w;
        ram_wdata = '0;
      end
      S_IDLE: begin
        s_tready  = 1'b1;
        ram_raddr = WAW'(rel_idx >> WORD_IDX_W);
      end
      S_SCAN: begin
        if (dvalid && fnd.found) begin
          ram_we    = 1'b1;
          ram_waddr = data_w;
          ram_wdata = rd_data | fnd.onehot;
        end
      end
      S_REL: begin
        ram_we    = rel_hit;
        ram_waddr = rel_w;
        ram_wdata = rd_data & ~(WORD_ONE << rel_bit);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_w      <= '0;
      more       <= 1'b0;
      dvalid     <= 1'b0;
      m_tvalid   <= 1'b0;
      first_page <= FIRST_PAGE_RST;
      page_count <= PAGE_COUNT_RST;
      free_left  <= free_base(FIRST_PAGE_RST, PAGE_COUNT_RST);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_w <= clr_w + WAW'(1);
      end
      // Advance the scan: one read issued per cycle until a hit or the last word.
      if (state == S_IDLE) begin
        more   <= in_acc && (cmd == CMD_ALLOC) && scan_ok;
        dvalid <= 1'b0;
      end else if (state == S_SCAN) begin
        dvalid <= more && !scan_done;
        if (scan_done || (issue_w == last_w)) begin
          more <= 1'b0;
        end
      end else begin
        more   <= 1'b0;
        dvalid <= 1'b0;
      end
      // Free count follows the bitmap writes.
      if (state == S_SCAN && dvalid && fnd.found && free_left != '0) begin
        free_left <= free_left - CFG_W'(1);
      end
      if (state == S_REL && rel_hit && free_left != FREE_MAX) begin
        free_left <= free_left + CFG_W'(1);
      end
      if (cfg_acc) begin
        if (cfg_index == CFG_FIRST_PAGE || cfg_index == CFG_PAGE_COUNT) begin
          first_page <= new_first;
          page_count <= new_count;
          free_left  <= free_base(new_first, new_count);
        end
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      issue_w    <= WAW'(ADDR_W'(first_page) >> WORD_IDX_W);
      start_w    <= WAW'(ADDR_W'(first_page) >> WORD_IDX_W);
      last_w     <= WAW'(total_m1 >> WORD_IDX_W);
      lo_bit     <= first_page[WORD_IDX_W-1:0];
      hi_bit     <= total_m1[WORD_IDX_W-1:0];
      rel_w      <= WAW'(rel_idx >> WORD_IDX_W);
      rel_bit    <= rel_idx[WORD_IDX_W-1:0];
      res_addr   <= '0;
      res_status <= (cmd == CMD_ALLOC) ? ST_OOM : ST_BAD_ADDR;
    end
    if (state == S_SCAN) begin
      data_w <= issue_w;
      if (more) begin
        issue_w <= issue_w + WAW'(1);
      end
      if (dvalid && fnd.found) begin
        res_addr   <= ADDR_W'(64'({data_w, fnd.bit_idx}) << PAGE_SHIFT);
        res_status <= ST_OK;
      end
    end
    if (state == S_REL) begin
      res_status <= rel_hit ? ST_OK : ST_NOT_USED;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {{(OUT_DATA_W - ADDR_W - CFG_W){1'b0}}, free_left, res_addr};
      m_tuser <= res_status;
    end
  end

  `PPA_ASSERT_IMP(a_no_result_in_clear, state == S_CLEAR, !m_tvalid, "result word during clearing pass")
  `PPA_ASSERT_IMP(a_scan_in_range, state == S_SCAN && more, issue_w <= last_w, "scan read beyond bound")
  `PPA_ASSERT_IMP(a_fail_zero_addr, m_tvalid && m_tuser != ST_OK, m_tdata[ADDR_W-1:0] == '0, "failed request returns an address")
  `PPA_ASSERT_NEXT(a_alloc_counts_down, state == S_SCAN && ram_we && free_left != '0, free_left == $past(free_left) - CFG_W'(1), "free count not lowered on allocation")

endmodule
